// ----- hw/rtl/tidt_pkg.sv -----
//------------------------------------------------------------------------------
// tidt_pkg
// Shared types and codes for the transaction ID tracker.
//------------------------------------------------------------------------------
`default_nettype none

package tidt_pkg;

  // Input function codes
  localparam logic [2:0] FUNC_START      = 3'd0;
  localparam logic [2:0] FUNC_COMPLETE   = 3'd1;
  localparam logic [2:0] FUNC_CANCEL     = 3'd2;
  localparam logic [2:0] FUNC_SWEEP      = 3'd3;
  localparam logic [2:0] FUNC_CANCEL_ALL = 3'd4;
  localparam logic [2:0] FUNC_QUERY      = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_STARTED   = 3'd0;
  localparam logic [2:0] KIND_COMPLETED = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
  localparam logic [2:0] KIND_QUERY     = 3'd4;
  localparam logic [2:0] KIND_FULL      = 3'd5;

  localparam logic [7:0] FIRST_ID = 8'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  txn_id;
    logic [15:0] timeout_ms;
    logic [31:0] now_ms;
    logic [7:0]  resp_code;
    logic [31:0] resp_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_id;
    logic [7:0]  out_code;
    logic [31:0] out_data;
    logic        is_pending;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_ADV,
    ST_DECIDE,
    ST_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request, clear scan
    logic scan_step;  // evaluate one slot, bump slot counter
    logic adv_start;  // begin ID advance, restart scan
    logic adv_step;   // evaluate one slot against candidate
    logic adv_next;   // move candidate forward, restart scan
    logic commit;     // apply write/clear for current op
    logic emit;       // load output register
    logic emit_full;  // output kind full
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;   // slot counter at last slot
    logic hit_now;     // current slot is a sweep/cancel-all hit
    logic found;       // id match seen
    logic free_found;  // free slot seen
    logic adv_hit;     // candidate is pending and not the taken id
    logic more_hits;   // later-hit flag, tied low by the datapath
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/transaction_id_tracker_unit.sv -----
//------------------------------------------------------------------------------
// transaction_id_tracker_unit
// Outstanding transaction table with per-entry timeout.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, payload in_data_i) carries start,
//   complete, cancel, sweep, cancel-all and query items. Output channel
//   (out_valid_o/out_ready_i, payload out_data_o) returns result transfers;
//   the final transfer of an item has last set.
//   Every item walks the slot table one slot a cycle unless a stall holds it.
//   Complete, cancel and query then pass a decide state; query, or a found
//   ID, moves on to an output state that loads the result register.
//   A start that finds a slot also walks the table once per ID candidate
//   to skip pending IDs; a full table goes straight to the output state.
//   Sweep and cancel-all report each hit slot while walking, one per cycle
//   unless the receiver stalls, and are ready again when the walk ends.
//   An item is taken only while the sequencer is idle.
//   Reset clears all valid bits and sets the ID pointer to one.
//   A stalled receiver holds the result register and pauses a sweep or cancel-all walk at a hit slot.
//------------------------------------------------------------------------------
`default_nettype none

module transaction_id_tracker_unit #(
  parameter int unsigned MaxPending = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tidt_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tidt_pkg::rsp_t  out_data_o
);
  import tidt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic out_busy;

  tidt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (in_data_i.func),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tidt_dp #(.MaxPending(MaxPending)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_busy_o  (out_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tidt_ctrl.sv -----
//------------------------------------------------------------------------------
// tidt_ctrl
// Sequencer: walks slots for each item and issues datapath commands.
//------------------------------------------------------------------------------
`default_nettype none

module tidt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      func_i,
  input  logic            out_busy_i,
  input  tidt_pkg::sts_t  sts_i,
  output tidt_pkg::cmd_t  cmd_o
);
  import tidt_pkg::*;

  state_e state_q, state_d;
  logic [2:0] func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      func_q  <= FUNC_START;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) func_q <= func_i;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Sweep and cancel-all emit per slot as they go
        if ((func_q == FUNC_SWEEP || func_q == FUNC_CANCEL_ALL) && sts_i.hit_now) begin
          if (!out_busy_i) begin
            cmd_o.emit   = 1'b1;
            cmd_o.commit = 1'b1;
            cmd_o.scan_step = 1'b1;
            if (sts_i.scan_done) state_d = ST_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_done) begin
            if (func_q == FUNC_SWEEP || func_q == FUNC_CANCEL_ALL) state_d = ST_IDLE;
            else state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (func_q == FUNC_START) begin
          if (sts_i.found || sts_i.free_found) begin
            cmd_o.adv_start = 1'b1;
            state_d = ST_ADV;
          end else begin
            state_d = ST_OUT;
          end
        end else if (func_q == FUNC_COMPLETE || func_q == FUNC_CANCEL
                     || func_q == FUNC_QUERY) begin
          if (sts_i.found || func_q == FUNC_QUERY) state_d = ST_OUT;
          else state_d = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd_o.adv_step = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.adv_hit) cmd_o.adv_next = 1'b1;
          else state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.emit      = 1'b1;
          cmd_o.commit    = 1'b1;
          cmd_o.emit_full = (func_q == FUNC_START) && !(sts_i.found || sts_i.free_found);
          state_d = ST_IDLE;
        end
      end
      ST_ALLOC: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Emission only in the scanning or output state
  a_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == ST_SCAN || state_q == ST_OUT))
    else $error("emit outside scan or output state");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted item did not start scan");
  a_adv_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.adv_start |-> (func_q == FUNC_START))
    else $error("ID advance outside start");

endmodule

`default_nettype wire

// ----- hw/rtl/tidt_dp.sv -----
//------------------------------------------------------------------------------
// tidt_dp
// Datapath: slot table, one-slot-per-cycle scan while stepped, ID pointer, output register.
//------------------------------------------------------------------------------
`default_nettype none

module tidt_dp #(
  parameter int unsigned MaxPending = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tidt_pkg::req_t  req_i,
  input  tidt_pkg::cmd_t  cmd_i,
  output tidt_pkg::sts_t  sts_o,
  output logic            out_busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tidt_pkg::rsp_t  rsp_o
);
  import tidt_pkg::*;

  localparam int unsigned IdxW = (MaxPending > 1) ? $clog2(MaxPending) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxPending - 1);

  logic [MaxPending-1:0] valid_q;
  logic [7:0]  txn_q   [MaxPending];
  logic [31:0] start_q [MaxPending];
  logic [15:0] limit_q [MaxPending];

  req_t           req_q;
  logic [IdxW-1:0] idx_q;
  logic           found_q, free_q;
  logic [IdxW-1:0] fslot_q, free_slot_q;
  logic [7:0]     next_id_q, cand_q;
  logic           adv_hit_q;
  rsp_t           rsp_q, rsp_d;
  logic           out_valid_q;

  logic [31:0] elapsed;
  logic        cur_match, cur_hit, cand_match, scan_done;
  logic [7:0]  cand_inc;
  logic [IdxW-1:0] wslot;
  logic        more_later;

  assign scan_done = (idx_q == LastIdx);
  assign elapsed   = req_q.now_ms - start_q[idx_q];
  assign cur_match = valid_q[idx_q] &&
                     (txn_q[idx_q] == ((req_q.func == FUNC_START) ? next_id_q : req_q.txn_id));
  assign cur_hit   = valid_q[idx_q] &&
                     ((req_q.func == FUNC_CANCEL_ALL) || (elapsed >= {16'd0, limit_q[idx_q]}));
  assign cand_match = valid_q[idx_q] && (txn_q[idx_q] == cand_q);
  assign cand_inc   = (cand_q == 8'hFF) ? FIRST_ID : cand_q + 8'd1;
  assign wslot      = found_q ? fslot_q : free_slot_q;

  always_comb begin
    sts_o            = '0;
    sts_o.scan_done  = scan_done;
    sts_o.hit_now    = cur_hit;
    sts_o.found      = found_q;
    sts_o.free_found = free_q;
    sts_o.adv_hit    = adv_hit_q || (cand_match && cand_q != next_id_q);
    sts_o.more_hits  = 1'b0;
  end

  // Any hit beyond current slot for last-flag
  always_comb begin
    logic [31:0] el;
    more_later = 1'b0;
    el = '0;
    for (int unsigned k = 0; k < MaxPending; k++) begin
      el = req_q.now_ms - start_q[k];
      if (IdxW'(k) > idx_q && valid_q[k] &&
          (req_q.func == FUNC_CANCEL_ALL || el >= {16'd0, limit_q[k]}))
        more_later = 1'b1;
    end
  end

  // Result word for the current operation
  always_comb begin
    rsp_d = '0;
    case (req_q.func)
      FUNC_START: begin
        rsp_d.kind   = cmd_i.emit_full ? KIND_FULL : KIND_STARTED;
        rsp_d.out_id = cmd_i.emit_full ? 8'd0 : next_id_q;
        rsp_d.last   = 1'b1;
      end
      FUNC_COMPLETE: begin
        rsp_d.kind     = KIND_COMPLETED;
        rsp_d.out_id   = req_q.txn_id;
        rsp_d.out_code = req_q.resp_code;
        rsp_d.out_data = req_q.resp_data;
        rsp_d.last     = 1'b1;
      end
      FUNC_CANCEL: begin
        rsp_d.kind   = KIND_CANCELLED;
        rsp_d.out_id = req_q.txn_id;
        rsp_d.last   = 1'b1;
      end
      FUNC_QUERY: begin
        rsp_d.kind       = KIND_QUERY;
        rsp_d.out_id     = req_q.txn_id;
        rsp_d.is_pending = found_q;
        rsp_d.last       = 1'b1;
      end
      default: begin
        rsp_d.kind   = (req_q.func == FUNC_SWEEP) ? KIND_TIMEOUT : KIND_CANCELLED;
        rsp_d.out_id = txn_q[idx_q];
        rsp_d.last   = !more_later;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      next_id_q   <= FIRST_ID;
      adv_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= scan_done ? '0 : idx_q + 1'b1;
        if (cur_match && !found_q) found_q <= 1'b1;
        if (!valid_q[idx_q] && !free_q) free_q <= 1'b1;
      end
      if (cmd_i.adv_start || cmd_i.adv_next) begin
        idx_q     <= '0;
        adv_hit_q <= 1'b0;
      end else if (cmd_i.adv_step) begin
        idx_q <= scan_done ? '0 : idx_q + 1'b1;
        if (cand_match && cand_q != next_id_q) adv_hit_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        if (req_q.func == FUNC_SWEEP || req_q.func == FUNC_CANCEL_ALL) begin
          valid_q[idx_q] <= 1'b0;
        end else if (req_q.func == FUNC_START) begin
          if (!cmd_i.emit_full) begin
            valid_q[wslot] <= 1'b1;
            next_id_q      <= cand_q;
          end
        end else if (req_q.func == FUNC_COMPLETE || req_q.func == FUNC_CANCEL) begin
          valid_q[fslot_q] <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.scan_step) begin
      if (cur_match && !found_q) fslot_q <= idx_q;
      if (!valid_q[idx_q] && !free_q) free_slot_q <= idx_q;
    end
    if (cmd_i.adv_start) cand_q <= (next_id_q == 8'hFF) ? FIRST_ID : next_id_q + 8'd1;
    else if (cmd_i.adv_next) cand_q <= cand_inc;
    if (cmd_i.commit && req_q.func == FUNC_START && !cmd_i.emit_full) begin
      txn_q[wslot]   <= next_id_q;
      start_q[wslot] <= req_q.now_ms;
      limit_q[wslot] <= req_q.timeout_ms;
    end
    if (cmd_i.emit) rsp_q <= rsp_d;
  end

  assign out_busy_o  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(rsp_q)))
    else $error("result changed while stalled");
  a_next_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != 8'd0)
    else $error("ID pointer reached zero");
  a_no_emit_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_busy_o)
    else $error("result overwritten");

endmodule

`default_nettype wire

// ----- verif/tidt_checker.sv -----
//------------------------------------------------------------------------------
// tidt_checker
// Watches both channels of the transaction ID tracker, predicts the result
// transfers of every accepted item and compares them in order, field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tidt_checker #(
  parameter int unsigned MaxPending = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  tidt_pkg::req_t   in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  tidt_pkg::rsp_t   out_data_i,
  output int               err_cnt_o,
  output int               pending_cnt_o
);
  import tidt_pkg::*;

  // Shadow copy of the table
  logic        tbl_valid [MaxPending];
  logic [7:0]  tbl_id    [MaxPending];
  logic [31:0] tbl_start [MaxPending];
  logic [15:0] tbl_limit [MaxPending];
  logic [7:0]  id_ptr;

  rsp_t rsp_q[$];

  assign pending_cnt_o = rsp_q.size();

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt_o++;
  endtask

  function automatic int lookup(input logic [7:0] id);
    for (int i = 0; i < MaxPending; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic rsp_t mk(input logic [2:0] k, input logic [7:0] id,
                              input logic [7:0] c, input logic [31:0] d,
                              input logic p);
    rsp_t r;
    r.kind = k; r.out_id = id; r.out_code = c; r.out_data = d;
    r.is_pending = p; r.last = 1'b0;
    return r;
  endfunction

  // Apply one item to the shadow table and queue its results
  task automatic predict_results(input req_t rq);
    rsp_t  res[$];
    int    s;
    logic [7:0] cand;
    case (rq.func)
      FUNC_START: begin
        s = lookup(id_ptr);
        if (s < 0)
          for (int i = 0; i < MaxPending; i++)
            if (!tbl_valid[i]) begin s = i; break; end
        if (s < 0) res = {res, mk(KIND_FULL, 8'd0, 8'd0, 32'd0, 1'b0)};
        else begin
          cand = id_ptr;
          do begin
            cand = cand + 8'd1;
            if (cand == 8'd0) cand = FIRST_ID;
          end while (lookup(cand) >= 0 && cand != id_ptr);
          tbl_valid[s] = 1'b1; tbl_id[s] = id_ptr;
          tbl_start[s] = rq.now_ms; tbl_limit[s] = rq.timeout_ms;
          res = {res, mk(KIND_STARTED, id_ptr, 8'd0, 32'd0, 1'b0)};
          id_ptr = cand;
        end
      end
      FUNC_COMPLETE: begin
        s = lookup(rq.txn_id);
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          res = {res, mk(KIND_COMPLETED, rq.txn_id, rq.resp_code, rq.resp_data, 1'b0)};
        end
      end
      FUNC_CANCEL: begin
        s = lookup(rq.txn_id);
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          res = {res, mk(KIND_CANCELLED, rq.txn_id, 8'd0, 32'd0, 1'b0)};
        end
      end
      FUNC_SWEEP:
        for (int i = 0; i < MaxPending; i++)
          if (tbl_valid[i] && (rq.now_ms - tbl_start[i]) >= {16'd0, tbl_limit[i]}) begin
            tbl_valid[i] = 1'b0;
            res = {res, mk(KIND_TIMEOUT, tbl_id[i], 8'd0, 32'd0, 1'b0)};
          end
      FUNC_CANCEL_ALL:
        for (int i = 0; i < MaxPending; i++)
          if (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
            res = {res, mk(KIND_CANCELLED, tbl_id[i], 8'd0, 32'd0, 1'b0)};
          end
      FUNC_QUERY:
        res = {res, mk(KIND_QUERY, rq.txn_id, 8'd0, 32'd0, lookup(rq.txn_id) >= 0)};
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) rsp_q = {rsp_q, res[i]};
  endtask

  // Compare one result transfer against the oldest expectation
  task automatic check_result(input rsp_t got);
    rsp_t exp_r;
    if (rsp_q.size() == 0) begin
      report($sformatf("unexpected result kind=%0d id=%0d", got.kind, got.out_id));
      return;
    end
    exp_r = rsp_q.pop_front();
    if (got.kind !== exp_r.kind)
      report($sformatf("kind got %0d exp %0d", got.kind, exp_r.kind));
    if (got.out_id !== exp_r.out_id)
      report($sformatf("out_id got %0d exp %0d", got.out_id, exp_r.out_id));
    if (got.out_code !== exp_r.out_code)
      report($sformatf("out_code got %0h exp %0h", got.out_code, exp_r.out_code));
    if (got.out_data !== exp_r.out_data)
      report($sformatf("out_data got %0h exp %0h", got.out_data, exp_r.out_data));
    if (got.is_pending !== exp_r.is_pending)
      report($sformatf("is_pending got %0b exp %0b", got.is_pending, exp_r.is_pending));
    if (got.last !== exp_r.last)
      report($sformatf("last got %0b exp %0b", got.last, exp_r.last));
  endtask

  initial begin
    err_cnt_o = 0;
    id_ptr    = FIRST_ID;
    for (int i = 0; i < MaxPending; i++) begin
      tbl_valid[i] = 1'b0; tbl_id[i] = '0; tbl_start[i] = '0; tbl_limit[i] = '0;
    end
  end

  // Sample both channels at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) predict_results(in_data_i);
    end
  end

endmodule

// ----- verif/tb_top.sv -----
//------------------------------------------------------------------------------
// tb_top
// Drives directed and random items into the transaction ID tracker with
// random idling on both channels; the checker predicts and compares results.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import tidt_pkg::*;

  localparam int unsigned MaxPending = 32;
  localparam int          IdleLimit  = 200000;
  // Unused function selectors
  localparam logic [2:0]  FuncRsvdLo = 3'd6;
  localparam logic [2:0]  FuncRsvdHi = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;
  int   err_cnt;
  int   pending_cnt;
  bit   busy_phase = 1'b0;
  int   idle_cycles = 0;
  logic [7:0] last_id = 8'd1;

  always #6 clk_i = ~clk_i;

  transaction_id_tracker_unit #(.MaxPending(MaxPending)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  tidt_checker #(.MaxPending(MaxPending)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .err_cnt_o     (err_cnt),
    .pending_cnt_o (pending_cnt)
  );

  // Receiver stalls at random except during the busy phase
  always @(posedge clk_i)
    out_ready <= busy_phase ? 1'b1 : ($urandom_range(99) >= 27);

  // Remember the last started ID so random items can target live ones
  always @(posedge clk_i)
    if (out_valid && out_ready && out_data.kind == KIND_STARTED) last_id <= out_data.out_id;

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one item, with optional idle gap first; valid stays up afterwards
  task automatic send(input logic [2:0] f, input logic [7:0] id,
                      input logic [15:0] tmo, input logic [31:0] now,
                      input logic [7:0] code, input logic [31:0] dat);
    req_t rq;
    rq.func = f; rq.txn_id = id; rq.timeout_ms = tmo; rq.now_ms = now;
    rq.resp_code = code; rq.resp_data = dat;
    if (!busy_phase)
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_rand(input logic [2:0] f, input logic [7:0] id);
    send(f, id, 16'($urandom), $urandom, 8'($urandom), $urandom);
  endtask

  initial begin
    logic [31:0] clock_ms;
    int          pick;
    logic [7:0]  tid;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-table cases, start extremes, close paths
    send(FUNC_SWEEP, 8'd0, 16'd0, 32'hFFFF_FFFF, 8'd0, 32'd0);
    send(FUNC_CANCEL_ALL, 8'd0, 16'd0, 32'd0, 8'd0, 32'd0);
    send(FUNC_COMPLETE, 8'd0, 16'd0, 32'd0, 8'hFF, 32'hFFFF_FFFF);
    send(FUNC_CANCEL, 8'd255, 16'd0, 32'd0, 8'd0, 32'd0);
    send(FUNC_QUERY, 8'd0, 16'd0, 32'd0, 8'd0, 32'd0);
    send(FuncRsvdLo, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send(FuncRsvdHi, 8'd0, 16'd0, 32'd0, 8'd0, 32'd0);
    send(FUNC_START, 8'd0, 16'd0, 32'hFFFF_FFF0, 8'd0, 32'd0);
    send(FUNC_START, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    send(FUNC_START, 8'd0, 16'd100, 32'hFFFF_FFF0, 8'd0, 32'd0);
    send(FUNC_QUERY, 8'd1, 16'd0, 32'd0, 8'd0, 32'd0);
    send(FUNC_COMPLETE, 8'd1, 16'd0, 32'd0, 8'hA5, 32'hDEAD_BEEF);
    send(FUNC_CANCEL, 8'd3, 16'd0, 32'd0, 8'd0, 32'd0);
    // Wrapped elapsed time: entry 2 should not expire, then should
    send(FUNC_SWEEP, 8'd0, 16'd0, 32'd10, 8'd0, 32'd0);
    send(FUNC_SWEEP, 8'd0, 16'd0, 32'h0001_0000, 8'd0, 32'd0);

    // Fill past capacity to hit the full case, then clear all
    busy_phase = 1'b1;
    for (int i = 0; i < MaxPending + 2; i++) send_rand(FUNC_START, 8'd0);
    busy_phase = 1'b0;
    send(FUNC_CANCEL_ALL, 8'd0, 16'd0, 32'd0, 8'd0, 32'd0);

    // Random: mostly starts and closes aimed at live IDs, under a slow clock
    clock_ms = $urandom;
    for (int n = 0; n < 50; n++) begin
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(4000);
      tid = ($urandom_range(3) == 0) ? 8'($urandom) : last_id - 8'($urandom_range(4));
      if (pick < 38)      send(FUNC_START, 8'($urandom), 16'($urandom_range(20000)),
                               clock_ms, 8'($urandom), $urandom);
      else if (pick < 43) send_rand(FUNC_START, tid);
      else if (pick < 60) send(FUNC_COMPLETE, tid, 16'($urandom), $urandom,
                               8'($urandom), $urandom);
      else if (pick < 70) send_rand(FUNC_CANCEL, tid);
      else if (pick < 82) send(FUNC_SWEEP, tid, 16'($urandom), clock_ms,
                               8'($urandom), $urandom);
      else if (pick < 85) send_rand(FUNC_SWEEP, tid);
      else if (pick < 88) send_rand(FUNC_CANCEL_ALL, tid);
      else if (pick < 97) send_rand(FUNC_QUERY, tid);
      else send_rand(3'($urandom_range(7)), tid);
    end
    in_valid <= 1'b0;

    // Drain, then let the walk settle
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
